>>> rtl/pkst_pkg.sv
package pkst_pkg;

	localparam int MAX_ENTRIES = 6;
	localparam int KEY_BITS    = 8;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int OPCODE_BITS   = 2;
	localparam int KEY_CODE_BITS = 8;
	localparam int COUNT_BITS    = 3;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RSVD    = 2'd3
	} opcode_t;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]    count_t;

	typedef struct packed {
		logic add;
		logic remove;
	} cell_ctrl_t;

endpackage

>>> rtl/pkst_op_if.sv
interface pkst_op_if
	import pkst_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OPCODE_BITS-1:0]   opcode;
	logic [KEY_CODE_BITS-1:0] key_code;

	modport source (output valid, output opcode, output key_code, input ready);
	modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

>>> rtl/pkst_res_if.sv
interface pkst_res_if
	import pkst_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  was_present;
	logic [COUNT_BITS-1:0] entry_count;
	logic                  press_dropped;

	modport source (output valid, output was_present, output entry_count,
		output press_dropped, input ready);
	modport sink   (input valid, input was_present, input entry_count,
		input press_dropped, output ready);
endinterface

>>> rtl/pkst_cell.sv
module pkst_cell
	import pkst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  key_t       key,
	input  logic       prev_valid,
	input  logic       next_valid,
	input  key_t       next_key,
	input  logic       hit_in,
	output logic       hit_out,
	output logic       valid,
	output key_t       key_out
);
	logic valid_q;
	key_t key_q;
	logic match;
	logic take_new;
	logic take_next;

	assign match     = valid_q && (key_q == key);
	assign hit_out   = hit_in | match;
	assign take_new  = ctrl.add && prev_valid && !valid_q;
	assign take_next = ctrl.remove && hit_out;

	// close the gap: every cell at or after the hit takes its neighbor's entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_next) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			key_q <= key;
		end else if (take_next) begin
			key_q <= next_key;
		end
	end

	assign valid   = valid_q;
	assign key_out = key_q;
endmodule

>>> rtl/pressed_key_set_tracker_top.sv
// channel  | dir | handshake     | payload
// op_ch    | in  | valid / ready | opcode[1:0], key_code[7:0]
// res_ch   | out | valid / ready | was_present, entry_count[2:0], press_dropped
//
// One item per cycle: the lookup ripples through the row of cells and the
// count update completes in the cycle of the transfer; the result is registered and shown in the next cycle.
// op_ch.ready is high while the result register is empty or being taken.
// A stalled result holds; no item is taken until it leaves.
// Reset empties the table and the result register.
module pressed_key_set_tracker_top
	import pkst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pkst_op_if.sink    op_ch,
	pkst_res_if.source res_ch
);
	logic                   accept;
	logic                   present;
	logic                   full;
	key_t                   key;
	opcode_t                op;
	cell_ctrl_t             ctrl;
	logic [MAX_ENTRIES-1:0] valid_vec;
	key_t                   key_vec [MAX_ENTRIES];
	logic [MAX_ENTRIES:0]   hit;

	logic   res_valid_q;
	logic   was_present_q;
	logic   dropped_q;
	count_t count_q;

	assign key     = KEY_BITS'(op_ch.key_code);
	assign op      = opcode_t'(op_ch.opcode);
	assign accept  = op_ch.valid && op_ch.ready;
	assign present = hit[MAX_ENTRIES];
	assign full    = valid_vec[MAX_ENTRIES-1];
	assign hit[0]  = 1'b0;

	assign ctrl.add    = accept && (op == OP_PRESS) && !present;
	assign ctrl.remove = accept && (op == OP_RELEASE) && present;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic prev_v;
		logic next_v;
		key_t next_k;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_rest
			assign prev_v = valid_vec[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_k = key_vec[i];
		end else begin : g_mid
			assign next_v = valid_vec[i+1];
			assign next_k = key_vec[i+1];
		end

		pkst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (key),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_key   (next_k),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.valid      (valid_vec[i]),
			.key_out    (key_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.add && !full) begin
			count_q <= count_q + count_t'(1);
		end else if (ctrl.remove) begin
			count_q <= count_q - count_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			was_present_q <= present;
			dropped_q     <= ctrl.add && full;
		end
	end

	assign op_ch.ready          = !res_valid_q || res_ch.ready;
	assign res_ch.valid         = res_valid_q;
	assign res_ch.was_present   = was_present_q;
	assign res_ch.entry_count   = COUNT_BITS'(count_q);
	assign res_ch.press_dropped = dropped_q;

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("count out of step with occupied cells");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0)
		else $error("occupied cells not packed at the head of the row");

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && dropped_q |-> count_q == count_t'(MAX_ENTRIES))
		else $error("press dropped with room in the table");

	a_release_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.remove |=> count_q == $past(count_q) - count_t'(1))
		else $error("release of a present key did not shrink the table");
endmodule

>>> dv/pressed_key_set_tracker_top_test.sv
`timescale 1ns / 100ps

module pressed_key_set_tracker_top_test;
	import pkst_pkg::*;

	typedef struct packed {
		logic                  was_present;
		logic [COUNT_BITS-1:0] entry_count;
		logic                  press_dropped;
	} key_report_t;

	typedef struct {
		opcode_t     op;
		key_t        key;
		bit          known;
		key_report_t report;
	} key_event_t;

	localparam int IDLE_PCT    = 22;
	localparam int RANDOM_ITEMS = 450;
	localparam int POOL_SIZE   = 8;
	localparam int HOLD_OFF    = 40;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;

	pkst_op_if  op_ch ();
	pkst_res_if res_ch ();

	pressed_key_set_tracker_top uut (
		.clk   (clk),
		.arst_n(arst_n),
		.op_ch (op_ch),
		.res_ch(res_ch)
	);

	key_t        held_keys [MAX_ENTRIES];
	int          held_count;
	key_event_t  event_plan [$];
	key_report_t pending_reports [$];
	int          in_count;
	int          mismatches;
	int          stall_cycles;
	bit          stim_done;
	bit          held_off;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit calm();
		return in_count >= 150 && in_count < 260;
	endfunction

	function automatic key_report_t track_key_event(opcode_t op, key_t key);
		key_report_t rep;
		int          slot;
		slot = MAX_ENTRIES;
		for (int i = 0; i < held_count; i++) begin
			if (slot == MAX_ENTRIES && held_keys[i] == key)
				slot = i;
		end
		rep.was_present   = slot < MAX_ENTRIES;
		rep.press_dropped = 1'b0;
		if (op == OP_PRESS && !rep.was_present) begin
			if (held_count < MAX_ENTRIES) begin
				held_keys[held_count] = key;
				held_count++;
			end else begin
				rep.press_dropped = 1'b1;
			end
		end else if (op == OP_RELEASE && rep.was_present) begin
			held_count--;
			held_keys[slot] = held_keys[held_count];
		end
		rep.entry_count = held_count[COUNT_BITS-1:0];
		return rep;
	endfunction

	function automatic void add_row(opcode_t op, key_t key, bit known, bit wp, int cnt,
		bit drop);
		key_event_t ev;
		ev.op                   = op;
		ev.key                  = key;
		ev.known                = known;
		ev.report.was_present   = wp;
		ev.report.entry_count   = cnt[COUNT_BITS-1:0];
		ev.report.press_dropped = drop;
		event_plan.push_back(ev);
	endfunction

	function automatic void build_plan();
		key_t    pool [POOL_SIZE];
		opcode_t op;
		int      pick;
		add_row(OP_QUERY,   8'h00, 1, 0, 0, 0);
		add_row(OP_RELEASE, 8'hFF, 1, 0, 0, 0);
		add_row(OP_PRESS,   8'h00, 1, 0, 1, 0);
		add_row(OP_PRESS,   8'h00, 1, 1, 1, 0);
		add_row(OP_PRESS,   8'hFF, 1, 0, 2, 0);
		add_row(OP_PRESS,   8'h01, 0, 0, 0, 0);
		add_row(OP_PRESS,   8'h80, 0, 0, 0, 0);
		add_row(OP_PRESS,   8'h55, 0, 0, 0, 0);
		add_row(OP_PRESS,   8'hAA, 1, 0, 6, 0);
		add_row(OP_PRESS,   8'h7F, 1, 0, 6, 1);
		add_row(OP_PRESS,   8'hFF, 1, 1, 6, 0);
		add_row(OP_RSVD,    8'h55, 1, 1, 6, 0);
		add_row(OP_QUERY,   8'hFE, 1, 0, 6, 0);
		add_row(OP_RELEASE, 8'h00, 1, 1, 5, 0);
		add_row(OP_QUERY,   8'hAA, 0, 0, 0, 0);
		add_row(OP_RELEASE, 8'hAA, 0, 0, 0, 0);
		add_row(OP_RELEASE, 8'hAA, 0, 0, 0, 0);
		add_row(OP_PRESS,   8'h7F, 0, 0, 0, 0);
		add_row(OP_RELEASE, 8'h7F, 0, 0, 0, 0);
		add_row(OP_RELEASE, 8'hFF, 0, 0, 0, 0);
		add_row(OP_RELEASE, 8'h01, 0, 0, 0, 0);
		add_row(OP_RELEASE, 8'h80, 0, 0, 0, 0);
		add_row(OP_RELEASE, 8'h55, 1, 1, 0, 0);
		add_row(OP_RELEASE, 8'h55, 1, 0, 0, 0);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 24 == 0) begin
				foreach (pool[j])
					pool[j] = key_t'($urandom_range(255));
			end
			if ($urandom_range(99) < 85) begin
				pick = $urandom_range(99);
				op = pick < 45 ? OP_PRESS : pick < 80 ? OP_RELEASE :
					pick < 95 ? OP_QUERY : OP_RSVD;
				add_row(op, pool[$urandom_range(POOL_SIZE - 1)], 0, 0, 0, 0);
			end else begin
				add_row(opcode_t'($urandom_range(3)), key_t'($urandom_range(255)),
					0, 0, 0, 0);
			end
		end
	endfunction

	initial begin
		arst_n         = 1'b0;
		op_ch.valid    = 1'b0;
		op_ch.opcode   = OP_PRESS;
		op_ch.key_code = '0;
		stim_done      = 1'b0;
		build_plan();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (event_plan[i]) begin
			while (!calm() && $urandom_range(99) < IDLE_PCT) begin
				op_ch.valid = 1'b0;
				@(negedge clk);
			end
			op_ch.valid    = 1'b1;
			op_ch.opcode   = event_plan[i].op;
			op_ch.key_code = event_plan[i].key;
			do @(posedge clk); while (!op_ch.ready);
			@(negedge clk);
		end
		op_ch.valid = 1'b0;
		stim_done   = 1'b1;
	end

	initial begin
		res_ch.ready = 1'b0;
		held_off     = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && !held_off && in_count >= 320) begin
				// hold off the result side so the block backs up into the input
				held_off     = 1'b1;
				res_ch.ready = 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
			res_ch.ready = arst_n && (calm() || $urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		held_count   = 0;
		in_count     = 0;
		mismatches   = 0;
		stall_cycles = 0;
	end

	always @(posedge clk) begin
		key_report_t expected;
		key_report_t predicted;
		if (arst_n) begin
			if (op_ch.valid && op_ch.ready) begin
				predicted = track_key_event(opcode_t'(op_ch.opcode), op_ch.key_code);
				pending_reports.push_back(event_plan[in_count].known ?
					event_plan[in_count].report : predicted);
				in_count++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (pending_reports.size() == 0) begin
					$error("result transfer with nothing expected");
					mismatches++;
				end else begin
					expected = pending_reports.pop_front();
					if (res_ch.was_present !== expected.was_present) begin
						$error("was_present: expected %0d, got %0d",
							expected.was_present, res_ch.was_present);
						mismatches++;
					end
					if (res_ch.entry_count !== expected.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							expected.entry_count, res_ch.entry_count);
						mismatches++;
					end
					if (res_ch.press_dropped !== expected.press_dropped) begin
						$error("press_dropped: expected %0d, got %0d",
							expected.press_dropped, res_ch.press_dropped);
						mismatches++;
					end
				end
			end
			if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		@(posedge stim_done);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
